>>> rtl/session_message_deframer_macros.svh
// ----------------------------------------------------------------------------
// session message deframer assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef SESSION_MESSAGE_DEFRAMER_MACROS_SVH
`define SESSION_MESSAGE_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge out of reset
`define SMD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("smd check failed");

// same-cycle implication
`define SMD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smd implication failed");

// next-cycle implication
`define SMD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smd next-cycle check failed");

`else

`define SMD_ASSERT(lbl, clk, rst, prop)
`define SMD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SMD_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// shared types, codes and helpers of the session message deframer
// ----------------------------------------------------------------------------
package smd_pkg;

  // frame type codes
  localparam logic [7:0] TYPE_DEBUG = 8'h2B;
  localparam logic [7:0] TYPE_UNSEQ = 8'h55;
  localparam logic [7:0] TYPE_SEQ   = 8'h53;
  localparam logic [7:0] TYPE_END   = 8'h5A;

  // register indexes
  localparam logic REG_INITIAL_SEQUENCE = 1'b0;
  localparam logic REG_IDLE_LIMIT       = 1'b1;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    EV_BYTE    = 2'd0,
    EV_EMPTY   = 2'd1,
    EV_END     = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    KIND_DEBUG = 2'd0,
    KIND_UNSEQ = 2'd1,
    KIND_SEQ   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    HDR_LEN_HI  = 2'd0,
    HDR_LEN_LO  = 2'd1,
    HDR_TYPE    = 2'd2,
    HDR_PAYLOAD = 2'd3
  } hdr_state_t;

  // one classified item for the back end
  typedef struct packed {
    logic       emit;   // a result goes out
    logic       inc;    // sequence counter steps
    event_t     ev;
    logic [7:0] data;
    kind_t      kind;
    logic       first;
    logic       last;
  } cmd_t;

  function automatic logic is_data_type(input logic [7:0] t);
    return (t == TYPE_DEBUG) || (t == TYPE_UNSEQ) || (t == TYPE_SEQ);
  endfunction

  function automatic kind_t kind_of(input logic [7:0] t);
    kind_t k;
    case (t)
      TYPE_UNSEQ: k = KIND_UNSEQ;
      TYPE_SEQ:   k = KIND_SEQ;
      default:    k = KIND_DEBUG;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/smd_front.sv
// ----------------------------------------------------------------------------
// smd_front
// accepts bytes and ticks, tracks frame headers and idle time, issues commands
// ----------------------------------------------------------------------------
`include "session_message_deframer_macros.svh"

module smd_front #(
  parameter int LENGTH_BITS     = 16,
  parameter int IDLE_TIMER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [7:0]         rx_byte,
  input  logic [15:0]        idle_limit,
  input  logic               q_full,
  output logic               push,
  output smd_pkg::cmd_t      cmd
);

  localparam int CMP_W = (IDLE_TIMER_BITS > 16) ? IDLE_TIMER_BITS : 16;

  smd_pkg::hdr_state_t        hdr, hdr_next;
  logic [7:0]                 len_hi, len_hi_next;
  logic [LENGTH_BITS-1:0]     frame_length, frame_length_next;
  logic [7:0]                 frame_type, frame_type_next;
  logic [LENGTH_BITS-1:0]     remaining, remaining_next;
  logic                       at_first, at_first_next;
  logic                       ended, ended_next;
  logic                       timed_out, timed_out_next;
  logic [IDLE_TIMER_BITS-1:0] idle, idle_next;

  logic                       accept;
  logic                       live;
  logic [IDLE_TIMER_BITS-1:0] idle_inc;
  logic                       tick_timeout;
  logic [15:0]                len_full;
  logic [LENGTH_BITS-1:0]     rem_dec;
  logic                       pay_last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign live     = accept && !ended && !timed_out;

  // saturating idle counter and limit compare
  assign idle_inc     = (&idle) ? idle : idle + 1'b1;
  assign tick_timeout = CMP_W'(idle_inc) > CMP_W'(idle_limit);

  assign len_full = {len_hi, rx_byte};
  assign rem_dec  = (remaining != '0) ? remaining - 1'b1 : remaining;
  assign pay_last = (rem_dec == '0);

  // next state
  always_comb begin
    hdr_next          = hdr;
    len_hi_next       = len_hi;
    frame_length_next = frame_length;
    frame_type_next   = frame_type;
    remaining_next    = remaining;
    at_first_next     = at_first;
    ended_next        = ended;
    timed_out_next    = timed_out;
    idle_next         = idle;
    if (live) begin
      if (mode) begin
        idle_next = idle_inc;
        if (tick_timeout) timed_out_next = 1'b1;
      end else begin
        idle_next = '0;
        case (hdr)
          smd_pkg::HDR_LEN_HI: begin
            len_hi_next = rx_byte;
            hdr_next    = smd_pkg::HDR_LEN_LO;
          end
          smd_pkg::HDR_LEN_LO: begin
            frame_length_next = len_full[LENGTH_BITS-1:0];
            hdr_next          = smd_pkg::HDR_TYPE;
          end
          smd_pkg::HDR_TYPE: begin
            frame_type_next = rx_byte;
            remaining_next  = frame_length;
            at_first_next   = 1'b1;
            if (frame_length != '0) begin
              hdr_next = smd_pkg::HDR_PAYLOAD;
            end else begin
              hdr_next = smd_pkg::HDR_LEN_HI;
              if (rx_byte == smd_pkg::TYPE_END) ended_next = 1'b1;
            end
          end
          smd_pkg::HDR_PAYLOAD: begin
            remaining_next = rem_dec;
            at_first_next  = pay_last;
            if (pay_last) begin
              hdr_next = smd_pkg::HDR_LEN_HI;
              if (frame_type == smd_pkg::TYPE_END) ended_next = 1'b1;
            end
          end
          default: hdr_next = smd_pkg::HDR_LEN_HI;
        endcase
      end
    end
  end

  // command outputs
  always_comb begin
    cmd = '0;
    if (mode) begin
      if (tick_timeout) begin
        cmd.emit = 1'b1;
        cmd.ev   = smd_pkg::EV_TIMEOUT;
      end
    end else begin
      case (hdr)
        smd_pkg::HDR_TYPE: begin
          cmd.inc = (rx_byte == smd_pkg::TYPE_SEQ);
          if (frame_length == '0) begin
            if (smd_pkg::is_data_type(rx_byte)) begin
              cmd.emit = 1'b1;
              cmd.ev   = smd_pkg::EV_EMPTY;
              cmd.kind = smd_pkg::kind_of(rx_byte);
              cmd.last = 1'b1;
            end else if (rx_byte == smd_pkg::TYPE_END) begin
              cmd.emit = 1'b1;
              cmd.ev   = smd_pkg::EV_END;
            end
          end
        end
        smd_pkg::HDR_PAYLOAD: begin
          if (smd_pkg::is_data_type(frame_type)) begin
            cmd.emit  = 1'b1;
            cmd.ev    = smd_pkg::EV_BYTE;
            cmd.data  = rx_byte;
            cmd.kind  = smd_pkg::kind_of(frame_type);
            cmd.first = at_first;
            cmd.last  = pay_last;
          end else if (pay_last && frame_type == smd_pkg::TYPE_END) begin
            cmd.emit = 1'b1;
            cmd.ev   = smd_pkg::EV_END;
          end
        end
        default: cmd = '0;
      endcase
    end
  end

  assign push = live && (cmd.emit || cmd.inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr          <= smd_pkg::HDR_LEN_HI;
      len_hi       <= '0;
      frame_length <= '0;
      frame_type   <= '0;
      remaining    <= '0;
      at_first     <= 1'b1;
      ended        <= 1'b0;
      timed_out    <= 1'b0;
      idle         <= '0;
    end else begin
      hdr          <= hdr_next;
      len_hi       <= len_hi_next;
      frame_length <= frame_length_next;
      frame_type   <= frame_type_next;
      remaining    <= remaining_next;
      at_first     <= at_first_next;
      ended        <= ended_next;
      timed_out    <= timed_out_next;
      idle         <= idle_next;
    end
  end

  // once halted nothing more reaches the back end
  `SMD_ASSERT_IMP(a_halt_silent, clk, rst, ended || timed_out, !push)
  // a payload state always holds a nonzero byte count
  `SMD_ASSERT_IMP(a_payload_count, clk, rst, hdr == smd_pkg::HDR_PAYLOAD, remaining != '0)

endmodule

>>> rtl/smd_queue.sv
// ----------------------------------------------------------------------------
// smd_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`include "session_message_deframer_macros.svh"

module smd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  smd_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output smd_pkg::cmd_t rd_cmd
);

  smd_pkg::cmd_t                entries [smd_pkg::QDEPTH];
  logic [smd_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [smd_pkg::QCNT_W-1:0]   count;
  logic                         do_push, do_pop;

  assign full     = (count == smd_pkg::QCNT_W'(smd_pkg::QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == smd_pkg::QPTR_W'(smd_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == smd_pkg::QPTR_W'(smd_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  `SMD_ASSERT(a_count_range, clk, rst, count <= smd_pkg::QCNT_W'(smd_pkg::QDEPTH))

endmodule

>>> rtl/smd_back.sv
// ----------------------------------------------------------------------------
// smd_back
// applies queued commands: sequence counter and registered result item
// ----------------------------------------------------------------------------
`include "session_message_deframer_macros.svh"

module smd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  smd_pkg::cmd_t q_cmd,
  output logic          q_pop,
  input  logic          seq_load,
  input  logic [63:0]   seq_value,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    event_res,
  output logic [7:0]    payload_byte,
  output logic [1:0]    kind,
  output logic          first_byte,
  output logic          last_byte,
  output logic [63:0]   sequence_value
);

  logic [63:0] seq, seq_next;

  assign q_pop    = q_valid && (!out_valid || out_ready);
  assign seq_next = seq + {63'd0, q_cmd.inc};

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= 64'd1;
      out_valid <= 1'b0;
    end else begin
      if (seq_load)                 seq <= seq_value;
      else if (q_pop && q_cmd.inc)  seq <= seq_next;
      if (out_ready)                out_valid <= 1'b0;
      if (q_pop && q_cmd.emit)      out_valid <= 1'b1;
    end
  end

  // result payload, loaded when a result-bearing command leaves the queue
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.emit) begin
      event_res      <= q_cmd.ev;
      payload_byte   <= q_cmd.data;
      kind           <= q_cmd.kind;
      first_byte     <= q_cmd.first;
      last_byte      <= q_cmd.last;
      sequence_value <= seq_next;
    end
  end

  // counter moves only on a load or a sequenced command
  `SMD_ASSERT_NXT(a_seq_hold, clk, rst, !seq_load && !(q_pop && q_cmd.inc), seq == $past(seq))

endmodule

>>> rtl/session_message_deframer.sv
// ----------------------------------------------------------------------------
// session_message_deframer
// receive-side deframer for a length-prefixed session protocol
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one item per transfer: mode 0
//   is a received stream byte in rx_byte, mode 1 is one timer tick.
//   output channel (out_valid/out_ready) carries at most one result item per
//   input item: payload bytes with kind/first/last marks, empty message, end
//   of session or idle timeout, always with the current sequence counter.
//   the apb port holds initial_sequence at 0x0 (writing it reloads the
//   counter) and idle_limit_ticks at 0x8; pready is tied high.
// timing:
//   one item per cycle sustained while out_ready stays high. an accepted item
//   is classified in the front, registered in the command queue and then in
//   the back end's output register. the front and back stages are split by a
//   two-entry command queue, so input keeps flowing while a result waits.
// stall:
//   when out_ready is low the output register holds, the queue fills and
//   in_ready drops once both queue entries are taken.
// reset:
//   rst clears the parser, idle timer and halt flags, empties the queue and
//   sets both registers and the counter to their defaults (1 and 15).
// ----------------------------------------------------------------------------
module session_message_deframer #(
  parameter int LENGTH_BITS     = 16,
  parameter int IDLE_TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_res,
  output logic [7:0]  payload_byte,
  output logic [1:0]  kind,
  output logic        first_byte,
  output logic        last_byte,
  output logic [63:0] sequence_value,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [63:0]   initial_sequence;
  logic [15:0]   idle_limit_ticks;
  logic          cfg_write;
  logic          reg_index;

  // front to queue to back
  logic          q_push;
  smd_pkg::cmd_t q_wr_cmd;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  smd_pkg::cmd_t q_rd_cmd;
  logic          seq_load;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  // registers sit 8 bytes apart, so bit 3 picks the register
  assign reg_index = paddr[3];
  assign seq_load  = cfg_write && (reg_index == smd_pkg::REG_INITIAL_SEQUENCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_sequence <= 64'd1;
      idle_limit_ticks <= 16'd15;
    end else if (cfg_write) begin
      case (reg_index)
        smd_pkg::REG_INITIAL_SEQUENCE: initial_sequence <= pwdata;
        smd_pkg::REG_IDLE_LIMIT:       idle_limit_ticks <= pwdata[15:0];
        default:                       initial_sequence <= initial_sequence;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      smd_pkg::REG_INITIAL_SEQUENCE: prdata = initial_sequence;
      smd_pkg::REG_IDLE_LIMIT:       prdata = {48'd0, idle_limit_ticks};
      default:                       prdata = '0;
    endcase
  end

  // header parsing, idle timer and classification
  smd_front #(
    .LENGTH_BITS     (LENGTH_BITS),
    .IDLE_TIMER_BITS (IDLE_TIMER_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .rx_byte    (rx_byte),
    .idle_limit (idle_limit_ticks),
    .q_full     (q_full),
    .push       (q_push),
    .cmd        (q_wr_cmd)
  );

  // decoupling queue
  smd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_cmd   (q_wr_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_rd_cmd)
  );

  // sequence counter and output register
  smd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_cmd          (q_rd_cmd),
    .q_pop          (q_pop),
    .seq_load       (seq_load),
    .seq_value      (pwdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .payload_byte   (payload_byte),
    .kind           (kind),
    .first_byte     (first_byte),
    .last_byte      (last_byte),
    .sequence_value (sequence_value)
  );

endmodule
